[rtl/tlat_pkg.sv]
`timescale 1ns / 1ps

package tlat_pkg;

  localparam int LINE_MAX_DEF = 64;

  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_SP  = 8'h20;

  // Whitespace is tab through carriage return, plus space.
  function automatic logic is_blank(input logic [7:0] c);
    return ((c >= CH_TAB) && (c <= CH_CR)) || (c == CH_SP);
  endfunction

endpackage

[rtl/tlat_ifs.sv]
`timescale 1ns / 1ps

interface tla_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface tla_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] line_byte;
  logic       line_last;

  modport source (output valid, output line_byte, output line_last, input ready);
  modport sink (input valid, input line_byte, input line_last, output ready);
endinterface

[rtl/text_line_assembler_trim_top.sv]
`timescale 1ns / 1ps

// Line framer with whitespace trim.
// in_ch takes one text byte per item. Carriage returns are dropped; other
// bytes fill a line store of LINE_MAX bytes. A line feed closes the line:
// leading and trailing whitespace is trimmed and the remaining bytes leave
// on out_ch, one per item, with line_last set on the final byte. Empty or
// all-whitespace lines, and lines that overflowed the store, emit nothing.
// Input takes one byte per cycle. The store has two banks, so the next line
// fills while the previous one drains; in_ch stalls only when both banks hold
// lines that have not yet been fully read out.
// After its line feed is accepted, the first byte of a line waits on the
// descriptor FIFO, the back end's run state and the output register; then one byte per
// cycle while out_ch.ready stays high, set by the single read port of the line store.
// When the receiver stalls, the current byte is held in the output register
// and reading pauses; input continues until both banks are taken.
// Reset (rst_n low, synchronous) empties the line and queue state and clears
// discard mode; store contents are left as they are.

module text_line_assembler_trim_top import tlat_pkg::*; #(
  parameter int LINE_MAX = LINE_MAX_DEF,
  localparam int IDX_W  = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1,
  localparam int ADDR_W = IDX_W + 1,
  localparam int DESC_W = 1 + 2 * IDX_W
) (
  input  logic       clk,
  input  logic       rst_n,
  tla_in_if.sink     in_ch,
  tla_out_if.source  out_ch
);

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;
  logic              desc_push;
  logic [DESC_W-1:0] desc_in;
  logic              desc_valid;
  logic [DESC_W-1:0] desc_out;
  logic              desc_pop;
  logic              free_valid;
  logic              free_bank;

  tlat_front #(
    .LINE_MAX (LINE_MAX)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .desc_push  (desc_push),
    .desc_data  (desc_in),
    .free_valid (free_valid),
    .free_bank  (free_bank)
  );

  tlat_fifo #(
    .W (DESC_W)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (desc_push),
    .din       (desc_in),
    .pop       (desc_pop),
    .not_empty (desc_valid),
    .dout      (desc_out)
  );

  tlat_back #(
    .LINE_MAX (LINE_MAX)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .desc_valid (desc_valid),
    .desc_data  (desc_out),
    .desc_pop   (desc_pop),
    .free_valid (free_valid),
    .free_bank  (free_bank),
    .out_ch     (out_ch)
  );

endmodule

[rtl/tlat_fifo.sv]
`timescale 1ns / 1ps

module tlat_fifo #(
  parameter int W = 13
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  input  logic         pop,
  output logic         not_empty,
  output logic [W-1:0] dout
);

  logic [W-1:0] ent_r [2];
  logic         wr_ptr_r, wr_ptr_nxt;
  logic         rd_ptr_r, rd_ptr_nxt;
  logic [1:0]   cnt_r, cnt_nxt;

  assign not_empty = (cnt_r != 2'd0);
  assign dout      = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = ~wr_ptr_r;
    end
    if (pop) begin
      rd_ptr_nxt = ~rd_ptr_r;
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= din;
    end
  end

endmodule

[rtl/tlat_front.sv]
`timescale 1ns / 1ps

module tlat_front import tlat_pkg::*; #(
  parameter int LINE_MAX = LINE_MAX_DEF,
  localparam int IDX_W  = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1,
  localparam int CNT_W  = $clog2(LINE_MAX + 1),
  localparam int ADDR_W = IDX_W + 1,
  localparam int DESC_W = 1 + 2 * IDX_W
) (
  input  logic              clk,
  input  logic              rst_n,
  tla_in_if.sink            in_ch,
  output logic              wr_en,
  output logic [ADDR_W-1:0] wr_addr,
  output logic [7:0]        wr_data,
  output logic              desc_push,
  output logic [DESC_W-1:0] desc_data,
  input  logic              free_valid,
  input  logic              free_bank
);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             discard_r, discard_nxt;
  logic             seen_r, seen_nxt;
  logic [IDX_W-1:0] first_r, first_nxt;
  logic [IDX_W-1:0] last_r, last_nxt;
  logic             bank_r, bank_nxt;
  logic [1:0]       busy_r, busy_nxt;
  logic             acc;
  logic [IDX_W-1:0] idx;
  logic             c_blank;

  // A bank is held until the back end has read the last byte of its line.
  assign in_ch.ready = !busy_r[bank_r];
  assign acc         = in_ch.valid && in_ch.ready;
  assign idx         = count_r[IDX_W-1:0];
  assign c_blank     = is_blank(in_ch.in_byte);
  assign wr_addr     = {bank_r, idx};
  assign wr_data     = in_ch.in_byte;
  assign desc_data   = {bank_r, first_r, last_r};

  always_comb begin
    count_nxt   = count_r;
    discard_nxt = discard_r;
    seen_nxt    = seen_r;
    first_nxt   = first_r;
    last_nxt    = last_r;
    bank_nxt    = bank_r;
    wr_en       = 1'b0;
    desc_push   = 1'b0;
    if (acc && (in_ch.in_byte != CH_CR)) begin
      if (in_ch.in_byte == CH_LF) begin
        if (!discard_r && seen_r) begin
          desc_push = 1'b1;
          bank_nxt  = ~bank_r;
        end
        discard_nxt = 1'b0;
        count_nxt   = '0;
        seen_nxt    = 1'b0;
      end else if (!discard_r) begin
        if (count_r < CNT_W'(LINE_MAX)) begin
          wr_en     = 1'b1;
          count_nxt = count_r + 1'b1;
          if (!c_blank) begin
            last_nxt = idx;
            if (!seen_r) begin
              first_nxt = idx;
              seen_nxt  = 1'b1;
            end
          end
        end else begin
          discard_nxt = 1'b1;
          count_nxt   = '0;
          seen_nxt    = 1'b0;
        end
      end
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    if (free_valid) begin
      busy_nxt[free_bank] = 1'b0;
    end
    if (desc_push) begin
      busy_nxt[bank_r] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      discard_r <= 1'b0;
      seen_r    <= 1'b0;
      bank_r    <= 1'b0;
      busy_r    <= 2'b00;
    end else begin
      count_r   <= count_nxt;
      discard_r <= discard_nxt;
      seen_r    <= seen_nxt;
      bank_r    <= bank_nxt;
      busy_r    <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    first_r <= first_nxt;
    last_r  <= last_nxt;
  end

`ifndef ASSERT_OFF
  a_discard_empty: assert property (@(posedge clk) disable iff (!rst_n)
    discard_r |-> (count_r == '0) && !seen_r)
    else $error("discarding with bytes still counted");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(LINE_MAX))
    else $error("line count beyond store size");

  a_trim_order: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r |-> (first_r <= last_r) && (count_r > CNT_W'(last_r)))
    else $error("trim bounds out of order");

  a_push_holds_bank: assert property (@(posedge clk) disable iff (!rst_n)
    desc_push |=> busy_r[$past(bank_r)])
    else $error("pushed line bank not marked busy");
`endif

endmodule

[rtl/tlat_back.sv]
`timescale 1ns / 1ps

module tlat_back import tlat_pkg::*; #(
  parameter int LINE_MAX = LINE_MAX_DEF,
  localparam int IDX_W  = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1,
  localparam int ADDR_W = IDX_W + 1,
  localparam int DESC_W = 1 + 2 * IDX_W
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  input  logic              desc_valid,
  input  logic [DESC_W-1:0] desc_data,
  output logic              desc_pop,
  output logic              free_valid,
  output logic              free_bank,
  tla_out_if.source         out_ch
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  logic [7:0]       mem [0:(2**ADDR_W)-1];
  state_t           state_r, state_nxt;
  logic             bank_r, bank_nxt;
  logic [IDX_W-1:0] ptr_r, ptr_nxt;
  logic [IDX_W-1:0] end_r, end_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_byte_r;
  logic             out_last_r;
  logic             issue;
  logic             at_end;

  // The registered read of the line store is the output register itself.
  assign issue  = (state_r == ST_RUN) && (!out_valid_r || out_ch.ready);
  assign at_end = (ptr_r == end_r);

  assign out_ch.valid     = out_valid_r;
  assign out_ch.line_byte = out_byte_r;
  assign out_ch.line_last = out_last_r;

  assign free_valid = issue && at_end;
  assign free_bank  = bank_r;

  always_comb begin
    state_nxt = state_r;
    bank_nxt  = bank_r;
    ptr_nxt   = ptr_r;
    end_nxt   = end_r;
    desc_pop  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (desc_valid) begin
          desc_pop  = 1'b1;
          bank_nxt  = desc_data[DESC_W-1];
          ptr_nxt   = desc_data[2*IDX_W-1:IDX_W];
          end_nxt   = desc_data[IDX_W-1:0];
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (issue) begin
          if (at_end) begin
            state_nxt = ST_IDLE;
          end else begin
            ptr_nxt = ptr_r + 1'b1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (issue) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bank_r <= bank_nxt;
    ptr_r  <= ptr_nxt;
    end_r  <= end_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (issue) begin
      out_byte_r <= mem[{bank_r, ptr_r}];
      out_last_r <= at_end;
    end
  end

`ifndef ASSERT_OFF
  a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (ptr_r <= end_r))
    else $error("read pointer passed end of line");

  a_free_last: assert property (@(posedge clk) disable iff (!rst_n)
    free_valid |=> out_valid_r && out_last_r)
    else $error("bank freed without last byte presented");

  a_idle_tail: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (!out_valid_r || out_last_r))
    else $error("idle while a line is half emitted");
`endif

endmodule

[verif/text_line_assembler_trim_top_test.sv]
`timescale 1ns / 1ps

module text_line_assembler_trim_top_test;
  import tlat_pkg::*;

  localparam int LINE_CAP     = LINE_MAX_DEF;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [7:0] line_byte;
    logic       line_last;
  } line_result_t;

  logic clk;
  logic rst_n;

  tla_in_if  in_ch();
  tla_out_if out_ch();

  text_line_assembler_trim_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Shadow copy of the framer state.
  logic [7:0]   line_buf [LINE_CAP];
  int           line_len;
  logic         dropping_line;
  line_result_t pending_line_bytes[$];
  line_result_t want;

  int tx_idle_pct;
  int rx_idle_pct;
  int sent_items;
  int fail_count;
  int cycle_count;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic blank_char(input logic [7:0] c);
    return ((c >= CH_TAB) && (c <= CH_CR)) || (c == CH_SP);
  endfunction

  // Applies one accepted byte to the shadow state and queues the trimmed line
  // when a line feed closes a line that was kept.
  function automatic void frame_byte(input logic [7:0] c);
    int lo;
    int hi;
    if (c == CH_CR) return;
    if (c == CH_LF) begin
      if (dropping_line) begin
        dropping_line = 1'b0;
        line_len = 0;
        return;
      end
      hi = line_len;
      while ((hi > 0) && blank_char(line_buf[hi-1])) hi--;
      lo = 0;
      while ((lo < hi) && blank_char(line_buf[lo])) lo++;
      for (int i = lo; i < hi; i++) begin
        pending_line_bytes.push_back('{line_byte: line_buf[i], line_last: (i + 1 == hi)});
      end
      line_len = 0;
      return;
    end
    if (dropping_line) return;
    if (line_len < LINE_CAP) begin
      line_buf[line_len] = c;
      line_len++;
    end else begin
      line_len = 0;
      dropping_line = 1'b1;
    end
  endfunction

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL text_line_assembler_trim_top");
      $finish;
    end
  end

  // Input items are applied to the shadow state before results are checked,
  // so a line and its first byte never race.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) frame_byte(in_ch.in_byte);
      if (out_ch.valid && out_ch.ready) begin
        if (pending_line_bytes.size() == 0) begin
          $error("unexpected item: line_byte %h line_last %b",
                 out_ch.line_byte, out_ch.line_last);
          fail_count++;
        end else begin
          want = pending_line_bytes.pop_front();
          if (out_ch.line_byte !== want.line_byte) begin
            $error("line_byte: expected %h, got %h", want.line_byte, out_ch.line_byte);
            fail_count++;
          end
          if (out_ch.line_last !== want.line_last) begin
            $error("line_last: expected %b, got %b", want.line_last, out_ch.line_last);
            fail_count++;
          end
        end
      end
    end
  end

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    sent_items++;
  endtask

  function automatic logic [7:0] rand_blank();
    case ($urandom_range(0, 5))
      0: return CH_TAB;
      1: return 8'h0B;
      2: return 8'h0C;
      3: return CH_CR;
      default: return CH_SP;
    endcase
  endfunction

  // Any byte that lands in the store: neither carriage return nor line feed.
  function automatic logic [7:0] rand_stored_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while ((c == CH_CR) || (c == CH_LF));
    return c;
  endfunction

  function automatic logic [7:0] rand_body_char();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 7) return 8'($urandom_range(8'h21, 8'h7E));
    if (pick < 8) return rand_blank();
    return rand_stored_char();
  endfunction

  task automatic send_text(input logic [7:0] s[$]);
    foreach (s[i]) send_byte(s[i]);
  endtask

  task automatic send_stored_run(input int n);
    repeat (n) send_byte(rand_stored_char());
  endtask

  task automatic test_directed();
    send_byte(CH_LF);
    send_text({CH_SP, CH_TAB, 8'h0B, 8'h0C, CH_CR, CH_LF});
    send_text({8'h00, 8'hFF, "a", CH_CR, CH_SP, "b", CH_LF});
    send_text({"x", CH_LF});
    // Neighbors of the whitespace range are kept.
    send_text({8'h08, 8'h0E, 8'h21, 8'h1F, CH_LF});
  endtask

  task automatic test_full_and_overflow();
    // A full store emits every byte.
    send_byte("A");
    send_stored_run(LINE_CAP - 2);
    send_text({"Z", CH_LF});
    // One byte too many: the line is thrown away up to its line feed.
    send_stored_run(LINE_CAP + 1);
    send_text({"j", "u", "n", "k", CH_CR, CH_SP, CH_LF});
    send_text({"o", "k", CH_LF});
  endtask

  task automatic send_random_line();
    int lead;
    int body;
    int trail;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
      return;
    end
    lead  = $urandom_range(0, 3);
    trail = $urandom_range(0, 3);
    body  = ($urandom_range(0, 19) == 0) ? $urandom_range(LINE_CAP - 4, LINE_CAP + 6)
                                         : $urandom_range(0, 12);
    repeat (lead) send_byte(rand_blank());
    repeat (body) send_byte(rand_body_char());
    repeat (trail) send_byte(rand_blank());
    if ($urandom_range(0, 2) == 0) send_byte(CH_CR);
    send_byte(CH_LF);
  endtask

  task automatic test_random_lines(input int n_items, input int tx_pct, input int rx_pct);
    int stop_at;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    stop_at = sent_items + n_items;
    while (sent_items < stop_at) send_random_line();
  endtask

  initial begin
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.in_byte = 8'h00;
    line_len      = 0;
    dropping_line = 1'b0;
    sent_items    = 0;
    fail_count    = 0;
    cycle_count   = 0;
    tx_idle_pct   = 37;
    rx_idle_pct   = 53;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_full_and_overflow();
    test_random_lines(24, 37, 53);
    test_random_lines(24, 53, 37);
    test_random_lines(24, 0, 0);

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_line_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS text_line_assembler_trim_top");
    end else begin
      $display("FAIL text_line_assembler_trim_top");
    end
    $finish;
  end

endmodule
